@@ sv/session_handshake_checker_top_defines.svh @@
// Assertion macros for the session handshake checker.
// Used only by session_handshake_checker_top.sv; no other dependencies.
`ifndef SESSION_HANDSHAKE_CHECKER_TOP_DEFINES_SVH
`define SESSION_HANDSHAKE_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset
`define SHK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("shk invariant violated");
// Same-cycle implication
`define SHK_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shk implication violated");
// Next-cycle implication
`define SHK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shk next-cycle check violated");
`else
`define SHK_ASSERT_ALWAYS(lbl, prop)
`define SHK_ASSERT_IMPLIES(lbl, ante, cons)
`define SHK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/shk_pkg.sv @@
// Shared types and constants for the session handshake checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package shk_pkg;

  // Field widths
  localparam int unsigned COOKIE_W = 64;
  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Required payload lengths
  localparam logic [LEN_W-1:0] LEN_HELLO    = LEN_W'(16);
  localparam logic [LEN_W-1:0] LEN_ATTACH   = LEN_W'(16);
  localparam logic [LEN_W-1:0] LEN_SET_LINK = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_DETACH   = LEN_W'(0);

  typedef enum logic [2:0] {
    OP_OPEN     = 3'd0,
    OP_CLOSE    = 3'd1,
    OP_HELLO    = 3'd2,
    OP_ATTACH   = 3'd3,
    OP_SET_LINK = 3'd4,
    OP_TX_BATCH = 3'd5,
    OP_RX_BATCH = 3'd6,
    OP_DETACH   = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    RC_OK           = 4'd0,
    RC_INVALID_ARG  = 4'd1,
    RC_BAD_STATE    = 4'd2,
    RC_BAD_OWNER    = 4'd3,
    RC_BAD_MESSAGE  = 4'd4,
    RC_BAD_SEQUENCE = 4'd5,
    RC_BAD_VERSION  = 4'd6,
    RC_BAD_CAPS     = 4'd7,
    RC_BAD_MTU      = 4'd8,
    RC_BAD_DEPTH    = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    ST_CLOSED     = 3'd0,
    ST_OPENED     = 3'd1,
    ST_NEGOTIATED = 3'd2,
    ST_ATTACHED   = 3'd3,
    ST_LINK_UP    = 3'd4
  } life_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABI_VERSION  = 3'd0,
    CFG_DRIVER_CAPS  = 3'd1,
    CFG_REQUIRED_CAP = 3'd2,
    CFG_MIN_MTU      = 3'd3,
    CFG_MAX_PKT      = 3'd4,
    CFG_MAX_QDEPTH   = 3'd5
  } cfg_idx_t;

  // One control message
  typedef struct packed {
    op_t                 opcode;
    logic [COOKIE_W-1:0] owner_tag;
    logic [SEQ_W-1:0]    sequence_req;
    logic                header_valid;
    logic [LEN_W-1:0]    body_len;
    logic [WORD_W-1:0]   payload_word0;
    logic [WORD_W-1:0]   payload_word1;
    logic [WORD_W-1:0]   payload_word2;
    logic [WORD_W-1:0]   payload_word3;
    logic                batch_valid;
  } item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [HALF_W-1:0] abi_version;
    logic [WORD_W-1:0] driver_caps;
    logic [WORD_W-1:0] required_cap;
    logic [WORD_W-1:0] min_mtu;
    logic [WORD_W-1:0] max_packet_size;
    logic [HALF_W-1:0] max_queue_depth;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    abi_version:     HALF_W'(1),
    driver_caps:     WORD_W'(1),
    required_cap:    WORD_W'(1),
    min_mtu:         WORD_W'(68),
    max_packet_size: WORD_W'(65535),
    max_queue_depth: HALF_W'(1024)
  };

  // Session state
  typedef struct packed {
    life_t               life;
    logic [COOKIE_W-1:0] owner_id;
    logic [SEQ_W-1:0]    last_seq;
    logic [WORD_W-1:0]   caps_agreed;
    logic [WORD_W-1:0]   mtu_value;
    logic [HALF_W-1:0]   tx_depth;
    logic [HALF_W-1:0]   rx_depth;
  } session_t;

  localparam session_t SESSION_RESET = '{
    life:        ST_CLOSED,
    owner_id:    '0,
    last_seq:    '0,
    caps_agreed: '0,
    mtu_value:   '0,
    tx_depth:    '0,
    rx_depth:    '0
  };

endpackage

`default_nettype wire

@@ sv/shk_cfg_regs.sv @@
// Configuration register file for the session handshake checker.
// Depends on shk_pkg.
`default_nettype none

module shk_cfg_regs
  import shk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_ABI_VERSION:  cfg_nxt.abi_version     = wr_data[HALF_W-1:0];
        CFG_DRIVER_CAPS:  cfg_nxt.driver_caps     = wr_data[WORD_W-1:0];
        CFG_REQUIRED_CAP: cfg_nxt.required_cap    = wr_data[WORD_W-1:0];
        CFG_MIN_MTU:      cfg_nxt.min_mtu         = wr_data[WORD_W-1:0];
        CFG_MAX_PKT:      cfg_nxt.max_packet_size = wr_data[WORD_W-1:0];
        CFG_MAX_QDEPTH:   cfg_nxt.max_queue_depth = wr_data[HALF_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ sv/shk_session.sv @@
// Session state register: lifecycle, owner, last sequence, caps, MTU, depths.
// Depends on shk_pkg.
`default_nettype none

module shk_session
  import shk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic upd_en,
  input  session_t  session_nxt,
  output session_t  session
);

  session_t session_r;

  // Commit the evaluated next state when a transaction moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= SESSION_RESET;
    end else if (upd_en) begin
      session_r <= session_nxt;
    end
  end

  assign session = session_r;

endmodule

`default_nettype wire

@@ sv/shk_eval.sv @@
// Single-pass message check: status and next session state for one message.
// Depends on shk_pkg; purely combinational.
`default_nettype none

module shk_eval
  import shk_pkg::*;
(
  input  item_t    item,
  input  session_t cur,
  input  cfg_t     cfg,
  output status_t  status,
  output session_t nxt
);

  logic [HALF_W-1:0] vmin;
  logic [HALF_W-1:0] vmax;
  logic [HALF_W-1:0] tx_req;
  logic [HALF_W-1:0] rx_req;
  logic              len_bad;
  logic              seq_bad;
  logic              post_link;

  assign vmin   = item.payload_word0[HALF_W-1:0];
  assign vmax   = item.payload_word0[WORD_W-1:HALF_W];
  assign tx_req = item.payload_word1[HALF_W-1:0];
  assign rx_req = item.payload_word1[WORD_W-1:HALF_W];
  assign post_link = (cur.life == ST_ATTACHED) || (cur.life == ST_LINK_UP);

  // Fixed payload length for hello, attach, set-link and detach; other messages take any length
  always_comb begin
    case (item.opcode)
      OP_HELLO:    len_bad = item.body_len != LEN_HELLO;
      OP_ATTACH:   len_bad = item.body_len != LEN_ATTACH;
      OP_SET_LINK: len_bad = item.body_len != LEN_SET_LINK;
      OP_DETACH:   len_bad = item.body_len != LEN_DETACH;
      default:     len_bad = 1'b0;
    endcase
  end

  // All-ones is never a usable sequence number; a request must also exceed last_seq
  assign seq_bad = (item.sequence_req == '1) || (item.sequence_req <= cur.last_seq);

  // Checks in priority order; first failure wins, state unchanged on failure
  always_comb begin
    status = RC_OK;
    nxt    = cur;
    if (item.owner_tag == '0) begin
      status = RC_INVALID_ARG;
    end else if (item.opcode == OP_OPEN) begin
      if (cur.life != ST_CLOSED) begin
        status = RC_BAD_STATE;
      end else begin
        nxt.owner_id = item.owner_tag;
        nxt.life     = ST_OPENED;
      end
    end else if (cur.life == ST_CLOSED || cur.owner_id != item.owner_tag) begin
      status = RC_BAD_OWNER;
    end else if (item.opcode == OP_CLOSE) begin
      nxt = SESSION_RESET;
    end else if (!item.header_valid || len_bad) begin
      status = RC_BAD_MESSAGE;
    end else if (seq_bad) begin
      status = RC_BAD_SEQUENCE;
    end else begin
      case (item.opcode)
        OP_HELLO: begin
          if (cur.life != ST_OPENED) begin
            status = RC_BAD_STATE;
          end else if (item.payload_word2 != '0 || item.payload_word3 != '0) begin
            status = RC_BAD_MESSAGE;
          end else if (vmin > vmax || vmin > cfg.abi_version ||
                       vmax < cfg.abi_version) begin
            status = RC_BAD_VERSION;
          end else if ((item.payload_word1 & cfg.required_cap) != cfg.required_cap ||
                       (item.payload_word1 & ~cfg.driver_caps) != '0) begin
            status = RC_BAD_CAPS;
          end else begin
            nxt.caps_agreed = item.payload_word1 & cfg.driver_caps;
            nxt.life        = ST_NEGOTIATED;
          end
        end
        OP_ATTACH: begin
          if (cur.life != ST_NEGOTIATED) begin
            status = RC_BAD_STATE;
          end else if (item.payload_word3 != '0) begin
            status = RC_BAD_MESSAGE;
          end else if (item.payload_word0 < cfg.min_mtu ||
                       item.payload_word0 > cfg.max_packet_size) begin
            status = RC_BAD_MTU;
          end else if (tx_req == '0 || tx_req > cfg.max_queue_depth ||
                       rx_req == '0 || rx_req > cfg.max_queue_depth) begin
            status = RC_BAD_DEPTH;
          end else if (item.payload_word2 != cur.caps_agreed) begin
            status = RC_BAD_CAPS;
          end else begin
            nxt.mtu_value = item.payload_word0;
            nxt.tx_depth  = tx_req;
            nxt.rx_depth  = rx_req;
            nxt.life      = ST_ATTACHED;
          end
        end
        OP_SET_LINK: begin
          if (!post_link) begin
            status = RC_BAD_STATE;
          end else if (item.payload_word0 > WORD_W'(1) || item.payload_word1 != '0) begin
            status = RC_BAD_MESSAGE;
          end else begin
            nxt.life = item.payload_word0[0] ? ST_LINK_UP : ST_ATTACHED;
          end
        end
        OP_DETACH: begin
          if (!post_link && cur.life != ST_NEGOTIATED) begin
            status = RC_BAD_STATE;
          end else begin
            nxt.mtu_value = '0;
            nxt.tx_depth  = '0;
            nxt.rx_depth  = '0;
            nxt.life      = ST_NEGOTIATED;
          end
        end
        default: begin
          // Transmit and receive batches
          if (cur.life != ST_LINK_UP) begin
            status = RC_BAD_STATE;
          end else if (!item.batch_valid) begin
            status = RC_BAD_MESSAGE;
          end
        end
      endcase
      if (status == RC_OK) begin
        nxt.last_seq = item.sequence_req;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/session_handshake_checker_top.sv @@
// Session handshake checker, top level.
// One transaction per cycle; input stalls only while a result waits on out_stall.
// The input register feeds one pass of check logic into the result register;
// the session state is committed on the same edge, so the next message sees it.
// Reset (rst_n low, synchronous) closes the session and restores config defaults.
`default_nettype none
`include "session_handshake_checker_top_defines.svh"

module session_handshake_checker_top
  import shk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [COOKIE_W-1:0]   in_owner_tag,
  input  wire logic [SEQ_W-1:0]      in_sequence_req,
  input  wire logic                  in_header_valid,
  input  wire logic [LEN_W-1:0]      in_body_len,
  input  wire logic [WORD_W-1:0]     in_payload_word0,
  input  wire logic [WORD_W-1:0]     in_payload_word1,
  input  wire logic [WORD_W-1:0]     in_payload_word2,
  input  wire logic [WORD_W-1:0]     in_payload_word3,
  input  wire logic                  in_batch_valid,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 out_status,
  output logic [2:0]                 out_session_state,
  output logic [WORD_W-1:0]          out_negotiated_caps,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  item_t    item_r;
  logic     in_v_r;
  logic     out_v_r;
  status_t  out_status_r;
  life_t    out_life_r;
  logic [WORD_W-1:0] out_caps_r;

  logic     out_free;
  logic     adv;
  logic     in_take;
  cfg_t     cfg;
  session_t session;
  session_t session_nxt;
  status_t  eval_status;
  logic     attached_any;
  logic     seq_commit;

  // Pipeline control: result slot frees when empty or being taken
  assign out_free = !out_v_r || !out_stall;
  assign adv      = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  shk_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  shk_session u_session (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd_en      (adv),
    .session_nxt (session_nxt),
    .session     (session)
  );

  shk_eval u_eval (
    .item   (item_r),
    .cur    (session),
    .cfg    (cfg),
    .status (eval_status),
    .nxt    (session_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{
        opcode:         op_t'(in_opcode),
        owner_tag:      in_owner_tag,
        sequence_req:   in_sequence_req,
        header_valid:   in_header_valid,
        body_len:       in_body_len,
        payload_word0:  in_payload_word0,
        payload_word1:  in_payload_word1,
        payload_word2:  in_payload_word2,
        payload_word3:  in_payload_word3,
        batch_valid:    in_batch_valid
      };
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= eval_status;
      out_life_r   <= session_nxt.life;
      out_caps_r   <= session_nxt.caps_agreed;
    end
  end

  assign out_valid           = out_v_r;
  assign out_status          = out_status_r;
  assign out_session_state   = out_life_r;
  assign out_negotiated_caps = out_caps_r;

  // Terms for the checks below
  assign attached_any = (session.life == ST_ATTACHED) || (session.life == ST_LINK_UP);
  assign seq_commit   = adv && (eval_status == RC_OK) && (item_r.opcode != OP_OPEN) &&
                        (item_r.opcode != OP_CLOSE);

  // Checks on the session logic
  `SHK_ASSERT_ALWAYS(a_last_seq_not_max, session.last_seq != '1)
  `SHK_ASSERT_IMPLIES(a_closed_no_owner, session.life == ST_CLOSED, session.owner_id == '0)
  `SHK_ASSERT_IMPLIES(a_attached_has_depth, attached_any, session.tx_depth != '0 && session.rx_depth != '0)
  `SHK_ASSERT_NEXT(a_seq_commit, seq_commit, session.last_seq == $past(item_r.sequence_req))

endmodule

`default_nettype wire
